### src/vnhs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnhs_pkg: shared types and codes of the vacuum/nitrogen/heat sequencer
// Phase and subphase codes, the sequencer state record, the configuration
// record and the result record passed between the modules.
// ----------------------------------------------------------------------------
package vnhs_pkg;

    localparam int TIME_BITS   = 20;
    localparam int SETTLE_BITS = 8;
    localparam int PHASE_BITS  = 3;
    localparam int SUB_BITS    = 2;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = TIME_BITS;

    // configuration register indexes
    localparam logic [CFG_IDX_BITS-1:0] CFG_PROCESS_SECONDS  = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_NITROGEN_SECONDS = 2'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_HEATING_SECONDS  = 2'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_SETTLE_TICKS     = 2'd3;

    localparam logic [SETTLE_BITS-1:0] SETTLE_RESET = 8'd5;

    // main phases
    localparam logic [PHASE_BITS-1:0] PH_IDLE    = 3'd0;
    localparam logic [PHASE_BITS-1:0] PH_OPEN    = 3'd1;
    localparam logic [PHASE_BITS-1:0] PH_SETTLE  = 3'd2;
    localparam logic [PHASE_BITS-1:0] PH_WAITVAC = 3'd3;
    localparam logic [PHASE_BITS-1:0] PH_RUN     = 3'd4;
    localparam logic [PHASE_BITS-1:0] PH_DONE    = 3'd5;
    localparam logic [PHASE_BITS-1:0] PH_STOP    = 3'd6;
    localparam logic [PHASE_BITS-1:0] PH_HFAIL   = 3'd7;

    // run subphases
    localparam logic [SUB_BITS-1:0] SUB_VACUUM   = 2'd0;
    localparam logic [SUB_BITS-1:0] SUB_SWITCH   = 2'd1;
    localparam logic [SUB_BITS-1:0] SUB_NITROGEN = 2'd2;
    localparam logic [SUB_BITS-1:0] SUB_FINISHED = 2'd3;

    // item command
    localparam logic CMD_SCAN = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    typedef struct packed {
        logic [TIME_BITS-1:0]   process_seconds;
        logic [TIME_BITS-1:0]   nitrogen_seconds;
        logic [TIME_BITS-1:0]   heating_seconds;
        logic [SETTLE_BITS-1:0] settle_ticks;
    } cfg_t;

    typedef struct packed {
        logic [PHASE_BITS-1:0]  phase;
        logic [PHASE_BITS-1:0]  saved_phase;
        logic [SUB_BITS-1:0]    subphase;
        logic                   vac_drive;
        logic                   nitrogen_valve;
        logic                   heater;
        logic                   start_pending;
        logic                   process_tick_en;
        logic                   heating_tick_en;
        logic [SETTLE_BITS-1:0] settle_count;
        logic [TIME_BITS-1:0]   process_remaining;
        logic [TIME_BITS-1:0]   heating_remaining;
        logic                   last_start;
        logic                   last_stop;
    } seq_state_t;

    typedef struct packed {
        logic                  vacuum_valve_open;
        logic                  nitrogen_valve_open;
        logic                  heater_on;
        logic [PHASE_BITS-1:0] main_phase;
        logic [SUB_BITS-1:0]   run_subphase;
        logic [TIME_BITS-1:0]  process_left;
        logic [TIME_BITS-1:0]  heating_left;
        logic                  active;
    } result_t;

endpackage

### src/vnhs_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnhs_step: next-state logic of the sequencer
// Applies one scan or tick item to the current state and forms the result
// that reports the state after the item.
// ----------------------------------------------------------------------------
module vnhs_step
    import vnhs_pkg::*;
(
    input  seq_state_t st,
    input  cfg_t       cfg,
    input  logic       cmd,
    input  logic       start_button,
    input  logic       stop_button,
    input  logic       vacuum_ok,
    input  logic       heater_fault,
    output seq_state_t nx,
    output result_t    res
);

    always_comb begin
        nx = st;
        if (cmd == CMD_TICK) begin
            if (st.process_tick_en && (st.process_remaining != '0)) begin
                nx.process_remaining = st.process_remaining - 1'b1;
            end
            if (st.heating_tick_en && (st.heating_remaining != '0)) begin
                nx.heating_remaining = st.heating_remaining - 1'b1;
            end
            if (st.settle_count != '0) begin
                nx.settle_count = st.settle_count - 1'b1;
            end
        end else begin
            if (start_button && !st.last_start) begin
                nx.start_pending = 1'b1;
            end
            nx.last_start = start_button;
            if (stop_button && !st.last_stop) begin
                nx.phase = PH_STOP;
            end
            nx.last_stop = stop_button;

            // fault entry comes after the stop edge, so a stop is saved and resumed
            if (heater_fault && (nx.phase != PH_IDLE)) begin
                if (nx.phase != PH_HFAIL) begin
                    nx.saved_phase = nx.phase;
                end
                nx.phase           = PH_HFAIL;
                nx.process_tick_en = 1'b0;
                nx.heating_tick_en = 1'b0;
            end

            unique case (nx.phase)
                PH_IDLE: begin
                    if (nx.start_pending) begin
                        nx.phase = PH_OPEN;
                    end else begin
                        nx.vac_drive      = 1'b0;
                        nx.nitrogen_valve = 1'b0;
                        nx.heater         = 1'b0;
                    end
                end
                PH_OPEN: begin
                    nx.vac_drive    = 1'b1;
                    nx.settle_count = cfg.settle_ticks;
                    nx.phase        = PH_SETTLE;
                end
                PH_SETTLE: begin
                    if (nx.settle_count == '0) begin
                        nx.phase = PH_WAITVAC;
                    end
                end
                PH_WAITVAC: begin
                    if (vacuum_ok) begin
                        nx.start_pending   = 1'b0;
                        nx.phase           = PH_RUN;
                        nx.subphase        = SUB_VACUUM;
                        nx.heater          = 1'b1;
                        nx.process_tick_en = 1'b1;
                        nx.heating_tick_en = 1'b1;
                    end
                end
                PH_RUN: begin
                    unique case (nx.subphase)
                        SUB_VACUUM: begin
                            if (nx.process_remaining <= cfg.nitrogen_seconds) begin
                                nx.vac_drive = 1'b0;
                                nx.subphase  = SUB_SWITCH;
                            end
                        end
                        SUB_SWITCH: begin
                            nx.nitrogen_valve = 1'b1;
                            nx.subphase       = SUB_NITROGEN;
                        end
                        SUB_NITROGEN: begin
                            if (nx.process_remaining == '0) begin
                                nx.process_tick_en   = 1'b0;
                                nx.nitrogen_valve    = 1'b0;
                                nx.process_remaining = cfg.process_seconds;
                                nx.heating_remaining = cfg.heating_seconds;
                                nx.subphase          = SUB_FINISHED;
                                nx.phase             = PH_DONE;
                            end
                        end
                        SUB_FINISHED: begin
                        end
                    endcase
                    // heating check uses the timer after a possible reload
                    if (nx.heating_remaining == '0) begin
                        nx.heating_tick_en = 1'b0;
                        nx.heater          = 1'b0;
                    end
                end
                PH_DONE: begin
                end
                PH_STOP: begin
                    nx.start_pending     = 1'b0;
                    nx.vac_drive         = 1'b0;
                    nx.nitrogen_valve    = 1'b0;
                    nx.heater            = 1'b0;
                    nx.process_tick_en   = 1'b0;
                    nx.heating_tick_en   = 1'b0;
                    nx.process_remaining = cfg.process_seconds;
                    nx.heating_remaining = cfg.heating_seconds;
                    nx.subphase          = SUB_FINISHED;
                    nx.phase             = PH_IDLE;
                end
                PH_HFAIL: begin
                    if (!heater_fault) begin
                        nx.phase           = nx.saved_phase;
                        nx.process_tick_en = 1'b1;
                        nx.heating_tick_en = 1'b1;
                    end
                end
            endcase
        end
    end

    always_comb begin
        res.vacuum_valve_open   = nx.vac_drive;
        res.nitrogen_valve_open = nx.nitrogen_valve;
        res.heater_on           = nx.heater;
        res.main_phase          = nx.phase;
        res.run_subphase        = nx.subphase;
        res.process_left        = nx.process_remaining;
        res.heating_left        = nx.heating_remaining;
        res.active              = (nx.phase != PH_IDLE);
    end

endmodule

### src/vnhs_obuf.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vnhs_obuf: result register with skid stage
// Holds result beats for the output channel; takes a new beat while the
// current one is stalled, so the input side never waits on a single stall.
// ----------------------------------------------------------------------------
module vnhs_obuf
    import vnhs_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    push,
    input  result_t push_data,
    output logic    push_ready,
    output logic    out_valid,
    input  logic    out_ready,
    output result_t out_data
);

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;

    assign push_ready = !skid_valid_reg;
    assign out_valid  = out_valid_reg;
    assign out_data   = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (!out_valid_reg || out_ready) begin
            // output slot frees up: drain skid first, else take the new beat
            if (skid_valid_reg) begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg  <= push;
            end
        end else if (push) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!out_valid_reg || out_ready) begin
            out_data_reg <= skid_valid_reg ? skid_data_reg : push_data;
        end else if (push) begin
            skid_data_reg <= push_data;
        end
    end

endmodule

### src/vacuum_nitrogen_heat_sequencer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vacuum_nitrogen_heat_sequencer: fixture process sequencer
// Steps one fixture through vacuum, nitrogen and heating and drives the
// vacuum valve, the nitrogen valve and the heater.
// ----------------------------------------------------------------------------
// Each accepted beat is either a scan (cmd 0: button edges, heater fault,
// phase step) or a one-second tick (cmd 1: timer countdown) and yields one
// result beat with the drives, phase and timers after that item. The step
// is combinational logic from the state registers into the result
// register, so one beat is taken per clock while s_ready is high; a skid
// stage behind the result register takes one more beat while the output
// stalls, and s_ready drops only while both result slots are full.
// Configuration writes take effect at once and do not reload the timers;
// write them only while the block is idle.
// ----------------------------------------------------------------------------
module vacuum_nitrogen_heat_sequencer
    import vnhs_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    // configuration
    input  logic                     cfg_wr_en,
    input  logic [CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [CFG_DATA_BITS-1:0] cfg_wdata,
    // input channel
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic                     s_cmd,
    input  logic                     s_start_button,
    input  logic                     s_stop_button,
    input  logic                     s_vacuum_ok,
    input  logic                     s_heater_fault,
    // result channel
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic                     m_vacuum_valve_open,
    output logic                     m_nitrogen_valve_open,
    output logic                     m_heater_on,
    output logic [PHASE_BITS-1:0]    m_main_phase,
    output logic [SUB_BITS-1:0]      m_run_subphase,
    output logic [TIME_BITS-1:0]     m_process_left,
    output logic [TIME_BITS-1:0]     m_heating_left,
    output logic                     m_active
);

    cfg_t       cfg_reg;
    seq_state_t state_reg;
    seq_state_t state_next;
    result_t    step_res;
    result_t    out_res;
    logic       accept;

    assign accept = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.process_seconds  <= '0;
            cfg_reg.nitrogen_seconds <= '0;
            cfg_reg.heating_seconds  <= '0;
            cfg_reg.settle_ticks     <= SETTLE_RESET;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_PROCESS_SECONDS:  cfg_reg.process_seconds  <= cfg_wdata;
                CFG_NITROGEN_SECONDS: cfg_reg.nitrogen_seconds <= cfg_wdata;
                CFG_HEATING_SECONDS:  cfg_reg.heating_seconds  <= cfg_wdata;
                CFG_SETTLE_TICKS:     cfg_reg.settle_ticks     <= cfg_wdata[SETTLE_BITS-1:0];
            endcase
        end
    end

    vnhs_step u_step (
        .st           (state_reg),
        .cfg          (cfg_reg),
        .cmd          (s_cmd),
        .start_button (s_start_button),
        .stop_button  (s_stop_button),
        .vacuum_ok    (s_vacuum_ok),
        .heater_fault (s_heater_fault),
        .nx           (state_next),
        .res          (step_res)
    );

    // timers reset to the (reset) register values, which are zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= '{
                phase:             PH_IDLE,
                saved_phase:       PH_IDLE,
                subphase:          SUB_VACUUM,
                vac_drive:         1'b0,
                nitrogen_valve:    1'b0,
                heater:            1'b0,
                start_pending:     1'b0,
                process_tick_en:   1'b0,
                heating_tick_en:   1'b0,
                settle_count:      '0,
                process_remaining: '0,
                heating_remaining: '0,
                last_start:        1'b0,
                last_stop:         1'b0
            };
        end else if (accept) begin
            state_reg <= state_next;
        end
    end

    vnhs_obuf u_obuf (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (accept),
        .push_data  (step_res),
        .push_ready (s_ready),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_data   (out_res)
    );

    assign m_vacuum_valve_open   = out_res.vacuum_valve_open;
    assign m_nitrogen_valve_open = out_res.nitrogen_valve_open;
    assign m_heater_on           = out_res.heater_on;
    assign m_main_phase          = out_res.main_phase;
    assign m_run_subphase        = out_res.run_subphase;
    assign m_process_left        = out_res.process_left;
    assign m_heating_left        = out_res.heating_left;
    assign m_active              = out_res.active;

    // state moves only on an accepted beat
    a_state_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        !accept |=> $stable(state_reg))
        else $error("sequencer state changed without an accepted beat");

    // a scan with a heater fault outside idle lands in heater fail
    a_fault_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && (s_cmd == CMD_SCAN) && s_heater_fault
            && (state_reg.phase != PH_IDLE))
        |=> (state_reg.phase == PH_HFAIL))
        else $error("heater fault did not enter heater fail");

    // timers stay frozen while in heater fail
    a_fail_no_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg.phase == PH_HFAIL)
        |-> (!state_reg.process_tick_en && !state_reg.heating_tick_en))
        else $error("tick enable set during heater fail");

    // the reported phase matches the state after the step
    a_result_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !m_valid) |=> (m_valid && (m_main_phase == state_reg.phase)))
        else $error("result phase does not match sequencer state");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for the vacuum/nitrogen/heat sequencer
// Drives scan and tick beats through the input channel and keeps a cycle-free
// copy of the sequencer state. Each accepted beat queues the drives, phase and
// timers it should produce. Every result beat is compared field by field with
// the oldest queued entry. Directed sequences walk one full process and the
// heater fault cases. Random sequences with several timer settings follow,
// under changing sender and receiver idling.
// ----------------------------------------------------------------------------
module tb
    import vnhs_pkg::*;
();

    localparam int QUIET_LIMIT = 4000;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     cfg_wr_en = 1'b0;
    logic [CFG_IDX_BITS-1:0]  cfg_index = CFG_PROCESS_SECONDS;
    logic [CFG_DATA_BITS-1:0] cfg_wdata = '0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic                     s_cmd = CMD_SCAN;
    logic                     s_start_button = 1'b0;
    logic                     s_stop_button = 1'b0;
    logic                     s_vacuum_ok = 1'b0;
    logic                     s_heater_fault = 1'b0;
    logic                     m_valid;
    logic                     m_ready = 1'b1;
    logic                     m_vacuum_valve_open;
    logic                     m_nitrogen_valve_open;
    logic                     m_heater_on;
    logic [PHASE_BITS-1:0]    m_main_phase;
    logic [SUB_BITS-1:0]      m_run_subphase;
    logic [TIME_BITS-1:0]     m_process_left;
    logic [TIME_BITS-1:0]     m_heating_left;
    logic                     m_active;

    vacuum_nitrogen_heat_sequencer u_dut (
        .aclk                  (aclk),
        .aresetn               (aresetn),
        .cfg_wr_en             (cfg_wr_en),
        .cfg_index             (cfg_index),
        .cfg_wdata             (cfg_wdata),
        .s_valid               (s_valid),
        .s_ready               (s_ready),
        .s_cmd                 (s_cmd),
        .s_start_button        (s_start_button),
        .s_stop_button         (s_stop_button),
        .s_vacuum_ok           (s_vacuum_ok),
        .s_heater_fault        (s_heater_fault),
        .m_valid               (m_valid),
        .m_ready               (m_ready),
        .m_vacuum_valve_open   (m_vacuum_valve_open),
        .m_nitrogen_valve_open (m_nitrogen_valve_open),
        .m_heater_on           (m_heater_on),
        .m_main_phase          (m_main_phase),
        .m_run_subphase        (m_run_subphase),
        .m_process_left        (m_process_left),
        .m_heating_left        (m_heating_left),
        .m_active              (m_active)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // fixture configuration as written
    logic [TIME_BITS-1:0]   cfg_process = '0;
    logic [TIME_BITS-1:0]   cfg_nitrogen = '0;
    logic [TIME_BITS-1:0]   cfg_heating = '0;
    logic [SETTLE_BITS-1:0] cfg_settle = SETTLE_RESET;

    // fixture state after the last accepted beat
    logic [PHASE_BITS-1:0]  phase_now = PH_IDLE;
    logic [PHASE_BITS-1:0]  phase_saved = PH_IDLE;
    logic [SUB_BITS-1:0]    sub_now = SUB_VACUUM;
    logic                   vac_valve = 1'b0;
    logic                   n2_valve = 1'b0;
    logic                   heater = 1'b0;
    logic                   start_req = 1'b0;
    logic                   proc_count_en = 1'b0;
    logic                   heat_count_en = 1'b0;
    logic [SETTLE_BITS-1:0] settle_left = '0;
    logic [TIME_BITS-1:0]   proc_left = '0;
    logic [TIME_BITS-1:0]   heat_left = '0;
    logic                   prev_start = 1'b0;
    logic                   prev_stop = 1'b0;

    result_t fixture_reports[$];

    int mismatches = 0;
    int quiet_cycles = 0;
    int send_idle_pct = 0;
    int recv_stall_pct = 0;

    // button and fault levels carried between random beats
    logic start_lvl = 1'b0;
    logic stop_lvl = 1'b0;
    logic fault_lvl = 1'b0;

    task automatic advance_fixture(input logic cmd, input logic start, input logic stop,
                                   input logic vac_ok, input logic fault);
        result_t r;
        if (cmd == CMD_TICK) begin
            if (proc_count_en && proc_left != 0) proc_left = proc_left - 1'b1;
            if (heat_count_en && heat_left != 0) heat_left = heat_left - 1'b1;
            if (settle_left != 0) settle_left = settle_left - 1'b1;
        end else begin
            if (start && !prev_start) start_req = 1'b1;
            prev_start = start;
            if (stop && !prev_stop) phase_now = PH_STOP;
            prev_stop = stop;
            // fault entry comes after the stop edge, so a stop gets saved
            if (fault && phase_now != PH_IDLE) begin
                if (phase_now != PH_HFAIL) phase_saved = phase_now;
                phase_now = PH_HFAIL;
                proc_count_en = 1'b0;
                heat_count_en = 1'b0;
            end
            case (phase_now)
                PH_IDLE: begin
                    if (start_req) begin
                        phase_now = PH_OPEN;
                    end else begin
                        vac_valve = 1'b0;
                        n2_valve = 1'b0;
                        heater = 1'b0;
                    end
                end
                PH_OPEN: begin
                    vac_valve = 1'b1;
                    settle_left = cfg_settle;
                    phase_now = PH_SETTLE;
                end
                PH_SETTLE: begin
                    if (settle_left == 0) phase_now = PH_WAITVAC;
                end
                PH_WAITVAC: begin
                    if (vac_ok) begin
                        start_req = 1'b0;
                        phase_now = PH_RUN;
                        sub_now = SUB_VACUUM;
                        heater = 1'b1;
                        proc_count_en = 1'b1;
                        heat_count_en = 1'b1;
                    end
                end
                PH_RUN: begin
                    case (sub_now)
                        SUB_VACUUM: begin
                            if (proc_left <= cfg_nitrogen) begin
                                vac_valve = 1'b0;
                                sub_now = SUB_SWITCH;
                            end
                        end
                        SUB_SWITCH: begin
                            n2_valve = 1'b1;
                            sub_now = SUB_NITROGEN;
                        end
                        SUB_NITROGEN: begin
                            if (proc_left == 0) begin
                                proc_count_en = 1'b0;
                                n2_valve = 1'b0;
                                proc_left = cfg_process;
                                heat_left = cfg_heating;
                                sub_now = SUB_FINISHED;
                                phase_now = PH_DONE;
                            end
                        end
                        default: ;
                    endcase
                    // checked against the reloaded timer when the run just ended
                    if (heat_left == 0) begin
                        heat_count_en = 1'b0;
                        heater = 1'b0;
                    end
                end
                PH_STOP: begin
                    start_req = 1'b0;
                    vac_valve = 1'b0;
                    n2_valve = 1'b0;
                    heater = 1'b0;
                    proc_count_en = 1'b0;
                    heat_count_en = 1'b0;
                    proc_left = cfg_process;
                    heat_left = cfg_heating;
                    sub_now = SUB_FINISHED;
                    phase_now = PH_IDLE;
                end
                PH_HFAIL: begin
                    if (!fault) begin
                        phase_now = phase_saved;
                        proc_count_en = 1'b1;
                        heat_count_en = 1'b1;
                    end
                end
                default: ;
            endcase
        end
        r.vacuum_valve_open   = vac_valve;
        r.nitrogen_valve_open = n2_valve;
        r.heater_on           = heater;
        r.main_phase          = phase_now;
        r.run_subphase        = sub_now;
        r.process_left        = proc_left;
        r.heating_left        = heat_left;
        r.active              = (phase_now != PH_IDLE);
        fixture_reports.push_back(r);
    endtask

    // Starts at a falling edge; returns right after the accepting rising edge.
    task automatic send_beat(input logic cmd, input logic start, input logic stop,
                             input logic vac_ok, input logic fault);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
        s_valid = 1'b1;
        s_cmd = cmd;
        s_start_button = start;
        s_stop_button = stop;
        s_vacuum_ok = vac_ok;
        s_heater_fault = fault;
        do @(posedge aclk); while (!s_ready);
        advance_fixture(cmd, start, stop, vac_ok, fault);
    endtask

    task automatic scan_beat(input logic start, input logic stop, input logic vac_ok,
                             input logic fault);
        send_beat(CMD_SCAN, start, stop, vac_ok, fault);
    endtask

    // levels are ignored on a tick, so fill them with noise
    task automatic tick_beat();
        send_beat(CMD_TICK, 1'($urandom_range(1)), 1'($urandom_range(1)),
                  1'($urandom_range(1)), 1'($urandom_range(1)));
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid = 1'b0;
        while (fixture_reports.size() != 0) @(negedge aclk);
        repeat (3) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] value);
        wait_drained();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        case (idx)
            CFG_PROCESS_SECONDS:  cfg_process = value;
            CFG_NITROGEN_SECONDS: cfg_nitrogen = value;
            CFG_HEATING_SECONDS:  cfg_heating = value;
            CFG_SETTLE_TICKS:     cfg_settle = value[SETTLE_BITS-1:0];
            default: ;
        endcase
    endtask

    task automatic load_timing(input logic [TIME_BITS-1:0] process_s,
                               input logic [TIME_BITS-1:0] nitrogen_s,
                               input logic [TIME_BITS-1:0] heating_s,
                               input logic [SETTLE_BITS-1:0] settle);
        write_reg(CFG_PROCESS_SECONDS, process_s);
        write_reg(CFG_NITROGEN_SECONDS, nitrogen_s);
        write_reg(CFG_HEATING_SECONDS, heating_s);
        write_reg(CFG_SETTLE_TICKS, CFG_DATA_BITS'(settle));
    endtask

    task automatic load_short_timing();
        logic [TIME_BITS-1:0] p;
        p = TIME_BITS'($urandom_range(12, 3));
        load_timing(p, TIME_BITS'($urandom_range(p)), TIME_BITS'($urandom_range(14, 1)),
                    SETTLE_BITS'($urandom_range(3)));
    endtask

    // Mostly well-formed runs: start presses, vacuum usually good, occasional
    // stop presses and short heater fault bursts.
    task automatic run_random(input int count);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(99) < 45) begin
                tick_beat();
            end else begin
                if ($urandom_range(99) < 15) start_lvl = !start_lvl;
                if (stop_lvl) stop_lvl = ($urandom_range(1) == 0);
                else stop_lvl = ($urandom_range(99) < 3);
                if (fault_lvl) fault_lvl = ($urandom_range(99) >= 30);
                else fault_lvl = ($urandom_range(99) < 4);
                scan_beat(start_lvl, stop_lvl, $urandom_range(99) < 75, fault_lvl);
            end
        end
    endtask

    task automatic test_full_cycle();
        load_timing(20'd4, 20'd2, 20'd3, 8'd1);
        tick_beat();
        scan_beat(1'b0, 1'b0, 1'b0, 1'b1);  // fault while idle is ignored
        scan_beat(1'b1, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b1, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b1, 1'b0);  // settle count not yet zero
        tick_beat();
        tick_beat();                         // settle count holds at zero
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b1, 1'b0);
        tick_beat();
        tick_beat();
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);
        tick_beat();
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);  // run ends, timers reload
        tick_beat();
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);  // done phase holds
        tick_beat();
        scan_beat(1'b0, 1'b1, 1'b0, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);
    endtask

    task automatic test_heater_fault();
        scan_beat(1'b1, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b1, 1'b0, 1'b0, 1'b0);
        tick_beat();
        scan_beat(1'b0, 1'b0, 1'b0, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b1, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b1, 1'b1);
        scan_beat(1'b0, 1'b0, 1'b1, 1'b1);  // saved phase must stay run
        tick_beat();
        scan_beat(1'b0, 1'b0, 1'b1, 1'b0);
        scan_beat(1'b0, 1'b1, 1'b1, 1'b1);  // stop edge under fault is saved
        scan_beat(1'b0, 1'b1, 1'b1, 1'b0);
        scan_beat(1'b0, 1'b0, 1'b1, 1'b0);
    endtask

    task automatic test_random_short_timing();
        send_idle_pct = 0;
        recv_stall_pct = 0;
        load_short_timing();
        run_random(120);
    endtask

    task automatic test_random_max_timing();
        send_idle_pct = 87;
        recv_stall_pct = 0;
        load_timing('1, '1, '1, '1);
        run_random(60);
    endtask

    task automatic test_random_zero_timing();
        send_idle_pct = 0;
        recv_stall_pct = 87;
        load_timing('0, '0, '0, '0);
        run_random(80);
    endtask

    task automatic test_random_mixed();
        send_idle_pct = 9;
        recv_stall_pct = 9;
        load_short_timing();
        run_random(100);
        wait_drained();
        run_random(100);
    endtask

    function automatic void check_field(input string name, input logic [TIME_BITS-1:0] want,
                                        input logic [TIME_BITS-1:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
        end
    endfunction

    always @(negedge aclk) begin
        m_ready = ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge aclk) begin
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (fixture_reports.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected result beat, phase %0d", $time, m_main_phase);
            end else begin
                want = fixture_reports.pop_front();
                check_field("vacuum_valve_open", TIME_BITS'(want.vacuum_valve_open),
                            TIME_BITS'(m_vacuum_valve_open));
                check_field("nitrogen_valve_open", TIME_BITS'(want.nitrogen_valve_open),
                            TIME_BITS'(m_nitrogen_valve_open));
                check_field("heater_on", TIME_BITS'(want.heater_on), TIME_BITS'(m_heater_on));
                check_field("main_phase", TIME_BITS'(want.main_phase),
                            TIME_BITS'(m_main_phase));
                check_field("run_subphase", TIME_BITS'(want.run_subphase),
                            TIME_BITS'(m_run_subphase));
                check_field("process_left", want.process_left, m_process_left);
                check_field("heating_left", want.heating_left, m_heating_left);
                check_field("active", TIME_BITS'(want.active), TIME_BITS'(m_active));
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAILED: results differ");
            $finish;
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        test_full_cycle();
        test_heater_fault();
        test_random_short_timing();
        test_random_max_timing();
        test_random_zero_timing();
        test_random_mixed();
        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && fixture_reports.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
